/* rtl/fapd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fapd_pkg: shared types and constants of the flex angle PID drive
// Field widths, fixed-point constants, datapath command codes and the
// command and status structs between controller and datapath.
// ----------------------------------------------------------------------------
package fapd_pkg;

  // Field widths
  localparam int SP_W      = 20;
  localparam int ERR_W     = 21;
  localparam int DIFF_W    = ERR_W + 1;
  localparam int SPD_W     = 11;
  localparam int MAG_W     = 10;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KI = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DB = 2'd3;

  localparam logic [CFG_W-1:0] DB_RESET = 16'd512;

  // Shared multiplier
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 24;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Angle measurement, Q.8 degrees
  localparam int COEF_R    = 80321;
  localparam int COEF_L    = 83814;
  localparam int ANG_ROUND = 256;
  localparam int ANG_SH    = 9;
  localparam int ANGLE_OFS = 30208;

  localparam logic [ERR_W-1:0] ERR_MAX = 21'h0F_FFFF;
  localparam logic [ERR_W-1:0] ERR_MIN = 21'h10_0000;

  // Integral accumulator
  localparam int ISUM_W = 40;
  localparam int ISPLIT = 20;
  localparam int LO_W   = 36;
  localparam int HI_P_W = 37;
  localparam int IT_W   = HI_P_W + ISPLIT;
  localparam int IC_W   = 32;
  localparam logic signed [ISUM_W:0] ISUM_MAX = 41'sh7F_FFFF_FFFF;
  localparam logic signed [ISUM_W:0] ISUM_MIN = -41'sh7F_FFFF_FFFF;
  localparam logic signed [IT_W-1:0] ICLAMP_POS = 57'sd1638400000;
  localparam logic signed [IT_W-1:0] ICLAMP_NEG = -57'sd1638400000;

  // Term scales and drive division by 100 * 2^16
  localparam int P_SCALE   = 100;
  localparam int D_SCALE   = 10000;
  localparam int P_PROD_W  = 28;
  localparam int KD_PROD_W = 31;
  localparam int TOT_W     = 53;
  localparam int DIV_SH    = 16;
  localparam int T_W       = TOT_W - DIV_SH;
  localparam int T_LO_W    = 17;
  localparam int SAT_T     = 102400;
  localparam int RECIP     = 167773;
  localparam int RECIP_SH  = 24;
  localparam logic [MAG_W-1:0] MAG_MAX = 10'd1023;

  // Multiplier operand select
  typedef logic [3:0] fapd_mop_t;
  localparam fapd_mop_t MOP_NONE  = 4'd0;
  localparam fapd_mop_t MOP_RIGHT = 4'd1;
  localparam fapd_mop_t MOP_LEFT  = 4'd2;
  localparam fapd_mop_t MOP_E100  = 4'd3;
  localparam fapd_mop_t MOP_KP    = 4'd4;
  localparam fapd_mop_t MOP_KD    = 4'd5;
  localparam fapd_mop_t MOP_DIFF  = 4'd6;
  localparam fapd_mop_t MOP_ILO   = 4'd7;
  localparam fapd_mop_t MOP_IHI   = 4'd8;
  localparam fapd_mop_t MOP_RECIP = 4'd9;

  // Datapath register update select
  typedef logic [3:0] fapd_aop_t;
  localparam fapd_aop_t AOP_NONE  = 4'd0;
  localparam fapd_aop_t AOP_ACC   = 4'd1;
  localparam fapd_aop_t AOP_ANGLE = 4'd2;
  localparam fapd_aop_t AOP_ERR   = 4'd3;
  localparam fapd_aop_t AOP_CHECK = 4'd4;
  localparam fapd_aop_t AOP_INTEG = 4'd5;
  localparam fapd_aop_t AOP_ZERO  = 4'd6;
  localparam fapd_aop_t AOP_TOT_P = 4'd7;
  localparam fapd_aop_t AOP_TOT_D = 4'd8;
  localparam fapd_aop_t AOP_LO    = 4'd9;
  localparam fapd_aop_t AOP_IT    = 4'd10;
  localparam fapd_aop_t AOP_TOT_I = 4'd11;
  localparam fapd_aop_t AOP_ABS   = 4'd12;
  localparam fapd_aop_t AOP_SAT   = 4'd13;
  localparam fapd_aop_t AOP_QUOT  = 4'd14;

  typedef struct packed {
    logic      capture;
    fapd_mop_t mop;
    fapd_aop_t aop;
    logic      load_out;
  } fapd_cmd_t;

  typedef struct packed {
    logic outside;
  } fapd_stat_t;

endpackage
`default_nettype wire

/* rtl/fapd_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fapd_if: stream channels of the flex angle PID drive
// Input channel carries setpoint and two sensor samples; result channel
// carries the error, the two servo speed words and the drive magnitude.
// ----------------------------------------------------------------------------
interface fapd_in_if #(
  parameter int SAMPLE_BITS = 10
);
  logic                               valid;
  logic                               ready;
  logic signed [fapd_pkg::SP_W-1:0]   setpoint;
  logic        [SAMPLE_BITS-1:0]      right_sample;
  logic        [SAMPLE_BITS-1:0]      left_sample;

  modport source (output valid, output setpoint, output right_sample,
                  output left_sample, input ready);
  modport sink   (input valid, input setpoint, input right_sample,
                  input left_sample, output ready);
endinterface

interface fapd_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [fapd_pkg::ERR_W-1:0]  angle_error;
  logic        [fapd_pkg::SPD_W-1:0]  servo_a_speed;
  logic        [fapd_pkg::SPD_W-1:0]  servo_b_speed;
  logic        [fapd_pkg::MAG_W-1:0]  drive_magnitude;

  modport source (output valid, output angle_error, output servo_a_speed,
                  output servo_b_speed, output drive_magnitude, input ready);
  modport sink   (input valid, input angle_error, input servo_a_speed,
                  input servo_b_speed, input drive_magnitude, output ready);
endinterface
`default_nettype wire

/* rtl/fapd_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fapd_ctrl: sequencer of the flex angle PID drive
// Steps one item through angle, error, deadband check and the PID terms,
// issuing at most one multiplier pass and one register update per state.
// ----------------------------------------------------------------------------
module fapd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  fapd_pkg::fapd_stat_t stat,
  output fapd_pkg::fapd_cmd_t  cmd
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_MR   = 5'd1;
  localparam logic [4:0] S_ML   = 5'd2;
  localparam logic [4:0] S_ANG  = 5'd3;
  localparam logic [4:0] S_ERR  = 5'd4;
  localparam logic [4:0] S_CHK  = 5'd5;
  localparam logic [4:0] S_P    = 5'd6;
  localparam logic [4:0] S_KD   = 5'd7;
  localparam logic [4:0] S_D    = 5'd8;
  localparam logic [4:0] S_ILO  = 5'd9;
  localparam logic [4:0] S_IHI  = 5'd10;
  localparam logic [4:0] S_IADD = 5'd11;
  localparam logic [4:0] S_ICL  = 5'd12;
  localparam logic [4:0] S_ABS  = 5'd13;
  localparam logic [4:0] S_REC  = 5'd14;
  localparam logic [4:0] S_Q    = 5'd15;
  localparam logic [4:0] S_OUT  = 5'd16;

  logic [4:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Next state and command per step
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_MR;
        end
      end
      S_MR: begin
        cmd.mop   = fapd_pkg::MOP_RIGHT;
        state_nxt = S_ML;
      end
      S_ML: begin
        cmd.mop   = fapd_pkg::MOP_LEFT;
        cmd.aop   = fapd_pkg::AOP_ACC;
        state_nxt = S_ANG;
      end
      S_ANG: begin
        cmd.aop   = fapd_pkg::AOP_ANGLE;
        state_nxt = S_ERR;
      end
      S_ERR: begin
        cmd.aop   = fapd_pkg::AOP_ERR;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        cmd.mop   = fapd_pkg::MOP_E100;
        cmd.aop   = fapd_pkg::AOP_CHECK;
        state_nxt = S_P;
      end
      S_P: begin
        if (stat.outside) begin
          cmd.mop   = fapd_pkg::MOP_KP;
          cmd.aop   = fapd_pkg::AOP_INTEG;
          state_nxt = S_KD;
        end else begin
          cmd.aop   = fapd_pkg::AOP_ZERO;
          state_nxt = S_OUT;
        end
      end
      S_KD: begin
        cmd.mop   = fapd_pkg::MOP_KD;
        cmd.aop   = fapd_pkg::AOP_TOT_P;
        state_nxt = S_D;
      end
      S_D: begin
        cmd.mop   = fapd_pkg::MOP_DIFF;
        state_nxt = S_ILO;
      end
      S_ILO: begin
        cmd.mop   = fapd_pkg::MOP_ILO;
        cmd.aop   = fapd_pkg::AOP_TOT_D;
        state_nxt = S_IHI;
      end
      S_IHI: begin
        cmd.mop   = fapd_pkg::MOP_IHI;
        cmd.aop   = fapd_pkg::AOP_LO;
        state_nxt = S_IADD;
      end
      S_IADD: begin
        cmd.aop   = fapd_pkg::AOP_IT;
        state_nxt = S_ICL;
      end
      S_ICL: begin
        cmd.aop   = fapd_pkg::AOP_TOT_I;
        state_nxt = S_ABS;
      end
      S_ABS: begin
        cmd.aop   = fapd_pkg::AOP_ABS;
        state_nxt = S_REC;
      end
      S_REC: begin
        cmd.mop   = fapd_pkg::MOP_RECIP;
        cmd.aop   = fapd_pkg::AOP_SAT;
        state_nxt = S_Q;
      end
      S_Q: begin
        cmd.aop   = fapd_pkg::AOP_QUOT;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output beat valid: set on load, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

/* rtl/fapd_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fapd_dp: datapath of the flex angle PID drive
// Gain registers, one shared signed multiplier with a registered product,
// controller state (integral, last error, direction) and output register.
// ----------------------------------------------------------------------------
module fapd_dp #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic        [fapd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [fapd_pkg::CFG_W-1:0]     cfg_data,
  input  logic signed [fapd_pkg::SP_W-1:0]      in_setpoint,
  input  logic        [SAMPLE_BITS-1:0]         in_right_sample,
  input  logic        [SAMPLE_BITS-1:0]         in_left_sample,
  input  fapd_pkg::fapd_cmd_t                   cmd,
  output fapd_pkg::fapd_stat_t                  stat,
  output logic signed [fapd_pkg::ERR_W-1:0]     out_angle_error,
  output logic        [fapd_pkg::SPD_W-1:0]     out_servo_a_speed,
  output logic        [fapd_pkg::SPD_W-1:0]     out_servo_b_speed,
  output logic        [fapd_pkg::MAG_W-1:0]     out_drive_magnitude
);

  localparam int ACC_W = SAMPLE_BITS + 19;
  localparam int ANG_W = SAMPLE_BITS + 11;
  localparam int EF_W  = ANG_W + 2;

  // Configuration
  logic [fapd_pkg::CFG_W-1:0] kp_r, ki_r, kd_r, db_r;

  // Captured item
  logic signed [fapd_pkg::SP_W-1:0] sp_r;
  logic        [SAMPLE_BITS-1:0]    r_r, l_r;

  // Working registers
  logic signed [fapd_pkg::MUL_P_W-1:0] prod_r;
  logic signed [ACC_W-1:0]             acc_r;
  logic signed [ANG_W-1:0]             angle_r;
  logic signed [fapd_pkg::ERR_W-1:0]   err_r;
  logic                                outside_r;
  logic signed [fapd_pkg::DIFF_W-1:0]  diff_r;
  logic signed [fapd_pkg::TOT_W-1:0]   tot_r;
  logic        [fapd_pkg::LO_W-1:0]    lo_r;
  logic signed [fapd_pkg::IT_W-1:0]    it_r;
  logic        [fapd_pkg::T_W-1:0]     t_r;
  logic                                neg_r;
  logic                                sat_r;
  logic        [fapd_pkg::MAG_W-1:0]   mag_r;

  // Controller state
  logic signed [fapd_pkg::ISUM_W-1:0]  isum_r;
  logic signed [fapd_pkg::ERR_W-1:0]   prev_r;
  logic                                rev_r;

  // Output register
  logic signed [fapd_pkg::ERR_W-1:0]   o_err_r;
  logic        [fapd_pkg::SPD_W-1:0]   o_a_r, o_b_r;
  logic        [fapd_pkg::MAG_W-1:0]   o_mag_r;

  // Multiplier
  logic signed [fapd_pkg::MUL_A_W-1:0] mul_a;
  logic signed [fapd_pkg::MUL_B_W-1:0] mul_b;
  logic signed [fapd_pkg::MUL_P_W-1:0] mul_p;

  // Step results
  logic signed [ACC_W-1:0]             ang_diff, ang_sh;
  logic signed [ANG_W-1:0]             angle_nxt;
  logic signed [EF_W-1:0]              err_full;
  logic signed [fapd_pkg::ERR_W-1:0]   err_sat;
  logic        [fapd_pkg::ERR_W-1:0]   abs_err;
  logic signed [fapd_pkg::ISUM_W:0]    isum_sum;
  logic signed [fapd_pkg::ISUM_W-1:0]  isum_nxt;
  logic signed [fapd_pkg::DIFF_W-1:0]  diff_nxt;
  logic signed [fapd_pkg::IT_W-1:0]    it_nxt;
  logic signed [fapd_pkg::IC_W-1:0]    it_c;
  logic        [fapd_pkg::TOT_W-1:0]   tmag;
  logic        [fapd_pkg::MAG_W-1:0]   quot;
  logic        [fapd_pkg::MAG_W-1:0]   mag_fin;
  logic        [fapd_pkg::MAG_W-2:0]   half_mag;

  // Select multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mop)
      fapd_pkg::MOP_RIGHT: begin
        mul_a = fapd_pkg::MUL_A_W'(fapd_pkg::COEF_R);
        mul_b = fapd_pkg::MUL_B_W'(r_r);
      end
      fapd_pkg::MOP_LEFT: begin
        mul_a = fapd_pkg::MUL_A_W'(fapd_pkg::COEF_L);
        mul_b = fapd_pkg::MUL_B_W'(l_r);
      end
      fapd_pkg::MOP_E100: begin
        mul_a = fapd_pkg::MUL_A_W'(err_r);
        mul_b = fapd_pkg::MUL_B_W'(fapd_pkg::P_SCALE);
      end
      fapd_pkg::MOP_KP: begin
        mul_a = fapd_pkg::MUL_A_W'($signed(prod_r[fapd_pkg::P_PROD_W-1:0]));
        mul_b = fapd_pkg::MUL_B_W'(kp_r);
      end
      fapd_pkg::MOP_KD: begin
        mul_a = fapd_pkg::MUL_A_W'(fapd_pkg::D_SCALE);
        mul_b = fapd_pkg::MUL_B_W'(kd_r);
      end
      fapd_pkg::MOP_DIFF: begin
        mul_a = fapd_pkg::MUL_A_W'(prod_r[fapd_pkg::KD_PROD_W-1:0]);
        mul_b = fapd_pkg::MUL_B_W'(diff_r);
      end
      fapd_pkg::MOP_ILO: begin
        mul_a = fapd_pkg::MUL_A_W'(isum_r[fapd_pkg::ISPLIT-1:0]);
        mul_b = fapd_pkg::MUL_B_W'(ki_r);
      end
      fapd_pkg::MOP_IHI: begin
        mul_a = fapd_pkg::MUL_A_W'(
                  $signed(isum_r[fapd_pkg::ISUM_W-1:fapd_pkg::ISPLIT]));
        mul_b = fapd_pkg::MUL_B_W'(ki_r);
      end
      fapd_pkg::MOP_RECIP: begin
        mul_a = fapd_pkg::MUL_A_W'(fapd_pkg::RECIP);
        mul_b = fapd_pkg::MUL_B_W'(t_r[fapd_pkg::T_LO_W-1:0]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Per-step arithmetic
  always_comb begin
    // angle = offset + round((R term - L term) / 512)
    ang_diff  = acc_r - $signed(prod_r[ACC_W-1:0]);
    ang_sh    = ang_diff >>> fapd_pkg::ANG_SH;
    angle_nxt = ANG_W'(ang_sh) + ANG_W'(fapd_pkg::ANGLE_OFS);

    // error, saturated to the output field
    err_full = EF_W'(sp_r) - EF_W'(angle_r);
    if (err_full[EF_W-1:fapd_pkg::ERR_W-1] ==
        {(EF_W - fapd_pkg::ERR_W + 1){err_full[EF_W-1]}}) begin
      err_sat = err_full[fapd_pkg::ERR_W-1:0];
    end else if (err_full[EF_W-1]) begin
      err_sat = fapd_pkg::ERR_MIN;
    end else begin
      err_sat = fapd_pkg::ERR_MAX;
    end

    abs_err = err_r[fapd_pkg::ERR_W-1] ? fapd_pkg::ERR_W'(-err_r)
                                       : fapd_pkg::ERR_W'(err_r);

    // integral step with symmetric saturation
    isum_sum = (fapd_pkg::ISUM_W + 1)'(isum_r) + (fapd_pkg::ISUM_W + 1)'(err_r);
    if (isum_sum > fapd_pkg::ISUM_MAX) begin
      isum_nxt = fapd_pkg::ISUM_W'(fapd_pkg::ISUM_MAX);
    end else if (isum_sum < fapd_pkg::ISUM_MIN) begin
      isum_nxt = fapd_pkg::ISUM_W'(fapd_pkg::ISUM_MIN);
    end else begin
      isum_nxt = fapd_pkg::ISUM_W'(isum_sum);
    end

    diff_nxt = fapd_pkg::DIFF_W'(err_r) - fapd_pkg::DIFF_W'(prev_r);

    // I term: high partial product shifted over the low one
    it_nxt = {prod_r[fapd_pkg::HI_P_W-1:0], {fapd_pkg::ISPLIT{1'b0}}}
             + fapd_pkg::IT_W'(lo_r);
    if (it_r >= fapd_pkg::ICLAMP_POS) begin
      it_c = fapd_pkg::IC_W'(fapd_pkg::ICLAMP_POS);
    end else if (it_r <= fapd_pkg::ICLAMP_NEG) begin
      it_c = fapd_pkg::IC_W'(fapd_pkg::ICLAMP_NEG);
    end else begin
      it_c = fapd_pkg::IC_W'(it_r);
    end

    tmag = tot_r[fapd_pkg::TOT_W-1] ? fapd_pkg::TOT_W'(-tot_r)
                                    : fapd_pkg::TOT_W'(tot_r);

    // quotient by 100 through the reciprocal product
    quot    = prod_r[fapd_pkg::RECIP_SH+fapd_pkg::MAG_W-1:fapd_pkg::RECIP_SH];
    mag_fin = sat_r ? fapd_pkg::MAG_MAX : quot;

    half_mag = mag_r[fapd_pkg::MAG_W-1:1];
  end

  // Configuration and controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r   <= '0;
      ki_r   <= '0;
      kd_r   <= '0;
      db_r   <= fapd_pkg::DB_RESET;
      isum_r <= '0;
      prev_r <= '0;
      rev_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          fapd_pkg::CFG_KP: kp_r <= cfg_data;
          fapd_pkg::CFG_KI: ki_r <= cfg_data;
          fapd_pkg::CFG_KD: kd_r <= cfg_data;
          fapd_pkg::CFG_DB: db_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.aop == fapd_pkg::AOP_INTEG) begin
        isum_r <= isum_nxt;
      end
      if (cmd.aop == fapd_pkg::AOP_QUOT) begin
        rev_r <= neg_r && (sat_r || (quot != '0));
      end
      if (cmd.load_out) begin
        prev_r <= err_r;
      end
    end
  end

  // Capture, product register and working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sp_r <= in_setpoint;
      r_r  <= in_right_sample;
      l_r  <= in_left_sample;
    end
    if (cmd.mop != fapd_pkg::MOP_NONE) begin
      prod_r <= mul_p;
    end
    case (cmd.aop)
      fapd_pkg::AOP_ACC:   acc_r     <= $signed(prod_r[ACC_W-1:0])
                                        + ACC_W'(fapd_pkg::ANG_ROUND);
      fapd_pkg::AOP_ANGLE: angle_r   <= angle_nxt;
      fapd_pkg::AOP_ERR:   err_r     <= err_sat;
      fapd_pkg::AOP_CHECK: outside_r <= (abs_err >= fapd_pkg::ERR_W'(db_r));
      fapd_pkg::AOP_INTEG: diff_r    <= diff_nxt;
      fapd_pkg::AOP_ZERO:  mag_r     <= '0;
      fapd_pkg::AOP_TOT_P: tot_r     <= fapd_pkg::TOT_W'(prod_r);
      fapd_pkg::AOP_TOT_D: tot_r     <= tot_r + fapd_pkg::TOT_W'(prod_r);
      fapd_pkg::AOP_LO:    lo_r      <= prod_r[fapd_pkg::LO_W-1:0];
      fapd_pkg::AOP_IT:    it_r      <= it_nxt;
      fapd_pkg::AOP_TOT_I: tot_r     <= tot_r + fapd_pkg::TOT_W'(it_c);
      fapd_pkg::AOP_ABS: begin
        t_r   <= tmag[fapd_pkg::TOT_W-1:fapd_pkg::DIV_SH];
        neg_r <= tot_r[fapd_pkg::TOT_W-1];
      end
      fapd_pkg::AOP_SAT:   sat_r     <= (t_r >= fapd_pkg::T_W'(fapd_pkg::SAT_T));
      fapd_pkg::AOP_QUOT:  mag_r     <= mag_fin;
      default: ;
    endcase
    // Load the result beat
    if (cmd.load_out) begin
      o_err_r <= err_r;
      o_mag_r <= mag_r;
      if (!rev_r) begin
        o_a_r <= {2'b10, half_mag};
        o_b_r <= {1'b1, mag_r};
      end else begin
        o_a_r <= {1'b0, mag_r};
        o_b_r <= {2'b00, half_mag};
      end
    end
  end

  assign stat.outside        = outside_r;
  assign out_angle_error     = o_err_r;
  assign out_servo_a_speed   = o_a_r;
  assign out_servo_b_speed   = o_b_r;
  assign out_drive_magnitude = o_mag_r;

endmodule
`default_nettype wire

/* rtl/flex_angle_pid_drive.sv */
`default_nettype none
// One item is in work at a time: no new item is accepted until the result
// beat of the last one is loaded; an error inside the deadband skips the PID terms.
// Outside the deadband, work per item is set by the nine passes through the
// single shared 32x24 multiplier and the add steps.
// Reset (rst_n low, synchronous): gains 0, deadband 2 degrees, integral,
// last error and direction cleared, no result pending.
// ----------------------------------------------------------------------------
// flex_angle_pid_drive: PID servo drive for one flex-sensed bend angle
// Measures the angle from two flex sensor samples, runs a PID law with a
// deadband and clamped integral, and emits two servo speed words.
// ----------------------------------------------------------------------------
module flex_angle_pid_drive #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  fapd_in_if.sink                           in_ch,
  fapd_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [fapd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fapd_pkg::CFG_W-1:0]        cfg_data
);

  fapd_pkg::fapd_cmd_t  cmd;
  fapd_pkg::fapd_stat_t stat;

  // Sequencer
  fapd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Arithmetic and state
  fapd_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_setpoint         (in_ch.setpoint),
    .in_right_sample     (in_ch.right_sample),
    .in_left_sample      (in_ch.left_sample),
    .cmd                 (cmd),
    .stat                (stat),
    .out_angle_error     (out_ch.angle_error),
    .out_servo_a_speed   (out_ch.servo_a_speed),
    .out_servo_b_speed   (out_ch.servo_b_speed),
    .out_drive_magnitude (out_ch.drive_magnitude)
  );

endmodule
`default_nettype wire

/* rtl/fapd_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fapd_checker: port-level checks of the flex angle PID drive
// Watches the channels of the top level and flags reset, stall, occupancy
// and speed-word consistency slips.
// ----------------------------------------------------------------------------
module fapd_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [fapd_pkg::ERR_W-1:0]  angle_error,
  input wire logic [fapd_pkg::SPD_W-1:0]  servo_a_speed,
  input wire logic [fapd_pkg::SPD_W-1:0]  servo_b_speed,
  input wire logic [fapd_pkg::MAG_W-1:0]  drive_magnitude
);

  // No result pending right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat valid after reset");

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(angle_error)
      && $stable(servo_a_speed) && $stable(servo_b_speed)
      && $stable(drive_magnitude))
    else $error("stalled result beat changed");

  // One item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in work");

  // Speed words follow one direction and the magnitude
  a_speed_map: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (servo_b_speed[10] && servo_a_speed[10]
        && servo_b_speed[9:0] == drive_magnitude
        && servo_a_speed[9:0] == {1'b0, drive_magnitude[9:1]})
      || (!servo_b_speed[10] && !servo_a_speed[10]
        && servo_a_speed[9:0] == drive_magnitude
        && servo_b_speed[9:0] == {1'b0, drive_magnitude[9:1]}))
    else $error("speed words disagree with drive magnitude");

endmodule

bind flex_angle_pid_drive fapd_checker u_fapd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .angle_error     (out_ch.angle_error),
  .servo_a_speed   (out_ch.servo_a_speed),
  .servo_b_speed   (out_ch.servo_b_speed),
  .drive_magnitude (out_ch.drive_magnitude)
);
`default_nettype wire

/* dv/tb_flex_angle_pid_drive.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_flex_angle_pid_drive: self-checking bench for the flex angle PID drive
// Sends sensor beats in random bursts against a receiver that stalls on its
// own pattern. Each accepted beat is run through a behavioral PID model that
// keeps its own integral, last error and direction. Every result beat is
// then compared field by field in order.
// ----------------------------------------------------------------------------
module tb_flex_angle_pid_drive;
  import fapd_pkg::*;

  localparam int SAMPLE_BITS = 10;
  localparam int SMP_MAX     = (1 << SAMPLE_BITS) - 1;
  localparam longint SP_MAX  = 524287;
  localparam longint SP_MIN  = -524288;
  localparam longint ERR_HI  = 1048575;
  localparam longint ERR_LO  = -1048576;
  localparam longint ISUM_LIM    = 64'sd549755813887;
  localparam longint I_LIM       = 64'sd1638400000;
  localparam longint DRIVE_SCALE = 6553600;
  localparam longint R_GAIN      = 80321;
  localparam longint L_GAIN      = 83814;
  localparam longint ANGLE_BIAS  = 30208;
  localparam longint MAG_CAP     = 1023;
  localparam int STALL_MAX     = 40;
  localparam int GAP_MAX       = 20;
  localparam int SETTLE_CYCLES = 24;
  localparam int PHASES        = 8;
  localparam int PHASE_BEATS   = 244;

  typedef enum {SINK_OPEN, SINK_COIN, SINK_STALL} sink_mode_t;

  typedef struct {
    logic signed [ERR_W-1:0] angle_error;
    logic        [SPD_W-1:0] servo_a_speed;
    logic        [SPD_W-1:0] servo_b_speed;
    logic        [MAG_W-1:0] drive_magnitude;
  } drive_beat_t;

  // PID drive model and queue of expected drive beats
  class pid_drive_scoreboard;
    logic [CFG_W-1:0] kp, ki, kd, deadband;
    longint integral_sum;
    longint last_error;
    bit reverse;
    drive_beat_t expected_beats[$];
    int errors, accepted, inside_cnt, sat_cnt, reverse_cnt, clamp_cnt;

    function new();
      kp = '0;
      ki = '0;
      kd = '0;
      deadband = DB_RESET;
      integral_sum = 0;
      last_error = 0;
      reverse = 1'b0;
      errors = 0;
      accepted = 0;
      inside_cnt = 0;
      sat_cnt = 0;
      reverse_cnt = 0;
      clamp_cnt = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_KP: kp = val;
        CFG_KI: ki = val;
        CFG_KD: kd = val;
        CFG_DB: deadband = val;
        default: ;
      endcase
    endfunction

    // Bend angle in Q.8 degrees, rounded half up
    function longint sensed_angle(logic [SAMPLE_BITS-1:0] r, logic [SAMPLE_BITS-1:0] l);
      longint rv, lv, num;
      rv = r;
      lv = l;
      num = rv * R_GAIN - lv * L_GAIN;
      return ANGLE_BIAS + ((num + 256) >>> 9);
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    function void accept_sample(logic signed [SP_W-1:0] sp, logic [SAMPLE_BITS-1:0] r,
                                logic [SAMPLE_BITS-1:0] l);
      longint spv, err, abs_err, dbv, kpv, kiv, kdv;
      longint p_term, i_term, d_term, total, tmag, mag, a, b;
      bit neg;
      drive_beat_t beat;
      spv = sp;
      dbv = deadband;
      kpv = kp;
      kiv = ki;
      kdv = kd;
      err = spv - sensed_angle(r, l);
      if (err > ERR_HI) err = ERR_HI;
      if (err < ERR_LO) err = ERR_LO;
      abs_err = (err < 0) ? -err : err;
      mag = 0;
      accepted++;

      if (abs_err >= dbv) begin
        // accumulate and clamp the integral
        integral_sum += err;
        if (integral_sum > ISUM_LIM) integral_sum = ISUM_LIM;
        if (integral_sum < -ISUM_LIM) integral_sum = -ISUM_LIM;

        // sum the terms at a common scale of 1/(65536*100)
        p_term = kpv * err * 100;
        i_term = kiv * integral_sum;
        if (i_term >= I_LIM) begin
          i_term = I_LIM;
          clamp_cnt++;
        end else if (i_term <= -I_LIM) begin
          i_term = -I_LIM;
          clamp_cnt++;
        end
        d_term = kdv * (err - last_error) * 10000;
        total = p_term + i_term + d_term;

        // truncate toward zero, saturate magnitude on both signs
        neg = total < 0;
        tmag = (neg ? -total : total) / DRIVE_SCALE;
        reverse = neg && (tmag > 0);
        if (tmag > MAG_CAP) begin
          mag = MAG_CAP;
          sat_cnt++;
        end else begin
          mag = tmag;
        end
      end else begin
        inside_cnt++;
      end

      // map direction to the two speed words
      if (!reverse) begin
        a = 1024 + mag / 2;
        b = 1024 + mag;
      end else begin
        a = mag;
        b = mag / 2;
        reverse_cnt++;
      end
      last_error = err;

      beat.angle_error = err[ERR_W-1:0];
      beat.servo_a_speed = a[SPD_W-1:0];
      beat.servo_b_speed = b[SPD_W-1:0];
      beat.drive_magnitude = mag[MAG_W-1:0];
      expected_beats.push_back(beat);
    endfunction

    function void check_drive(drive_beat_t got);
      drive_beat_t want;
      if (expected_beats.size() == 0) begin
        $error("drive beat with no pending sample: angle_error %0d", got.angle_error);
        errors++;
        return;
      end
      want = expected_beats.pop_front();
      if (got.angle_error !== want.angle_error) begin
        $error("angle_error: expected %0d, got %0d", want.angle_error, got.angle_error);
        errors++;
      end
      if (got.servo_a_speed !== want.servo_a_speed) begin
        $error("servo_a_speed: expected %0d, got %0d", want.servo_a_speed,
               got.servo_a_speed);
        errors++;
      end
      if (got.servo_b_speed !== want.servo_b_speed) begin
        $error("servo_b_speed: expected %0d, got %0d", want.servo_b_speed,
               got.servo_b_speed);
        errors++;
      end
      if (got.drive_magnitude !== want.drive_magnitude) begin
        $error("drive_magnitude: expected %0d, got %0d", want.drive_magnitude,
               got.drive_magnitude);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   burst_left;
  int                   settings_cnt;

  fapd_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
  fapd_out_if out_ch ();

  pid_drive_scoreboard sb = new();

  flex_angle_pid_drive #(.SAMPLE_BITS(SAMPLE_BITS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #(8 * 1000000);
    $display("flex_angle_pid_drive test failed");
    $finish;
  end

  // Result side: check accepted beats, then pick the next ready level
  initial begin : drive_sink
    sink_mode_t mode;
    int mode_left, stall_left;
    drive_beat_t got;
    mode = SINK_OPEN;
    mode_left = 0;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        got.angle_error = out_ch.angle_error;
        got.servo_a_speed = out_ch.servo_a_speed;
        got.servo_b_speed = out_ch.servo_b_speed;
        got.drive_magnitude = out_ch.drive_magnitude;
        sb.check_drive(got);
      end
      if (mode_left == 0) begin
        mode = sink_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (mode)
        SINK_OPEN: out_ch.ready <= 1'b1;
        SINK_COIN: out_ch.ready <= 1'($urandom_range(0, 1));
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            out_ch.ready <= 1'b0;
          end else begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, STALL_MAX);
          end
        end
      endcase
    end
  end

  function automatic logic signed [SP_W-1:0] clamp_setpoint(longint v);
    if (v > SP_MAX) v = SP_MAX;
    else if (v < SP_MIN) v = SP_MIN;
    return v[SP_W-1:0];
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] nudge(logic [SAMPLE_BITS-1:0] v);
    int t;
    t = int'(v) + int'($urandom_range(0, 6)) - 3;
    if (t < 0) t = 0;
    if (t > SMP_MAX) t = SMP_MAX;
    return t[SAMPLE_BITS-1:0];
  endfunction

  function automatic logic [CFG_W-1:0] pick_gain(int typical);
    if ($urandom_range(0, 3) == 0) return CFG_W'($urandom);
    return CFG_W'($urandom_range(0, typical));
  endfunction

  function automatic logic [CFG_W-1:0] pick_deadband();
    if ($urandom_range(0, 7) == 0) return CFG_W'($urandom);
    return CFG_W'($urandom_range(0, 2048));
  endfunction

  // Present one beat, hold until accepted, then maybe close the burst
  task automatic send_item(input logic signed [SP_W-1:0] sp,
                           input logic [SAMPLE_BITS-1:0] r,
                           input logic [SAMPLE_BITS-1:0] l);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.setpoint <= sp;
    in_ch.right_sample <= r;
    in_ch.left_sample <= l;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.accept_sample(sp, r, l);
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, GAP_MAX);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
                                               : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Aim the setpoint at a chosen error from the sensed angle
  task automatic send_offset(input logic [SAMPLE_BITS-1:0] r,
                             input logic [SAMPLE_BITS-1:0] l, input longint offset);
    send_item(clamp_setpoint(sb.sensed_angle(r, l) + offset), r, l);
  endtask

  // Wait out every pending beat plus the block's latency
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic load_settings(input logic [CFG_W-1:0] kp, input logic [CFG_W-1:0] ki,
                               input logic [CFG_W-1:0] kd, input logic [CFG_W-1:0] db);
    drain();
    write_reg(CFG_KP, kp);
    write_reg(CFG_KI, ki);
    write_reg(CFG_KD, kd);
    write_reg(CFG_DB, db);
    cfg_we <= 1'b0;
    settings_cnt++;
  endtask

  task automatic directed_part();
    // field extremes with reset gains
    send_item(clamp_setpoint(SP_MAX), '0, '1);
    send_item(clamp_setpoint(SP_MIN), '1, '0);
    send_item('0, '0, '0);
    send_item('1, '1, '1);
    // both sides of the reset deadband edge
    send_offset(10'd512, 10'd512, 0);
    send_offset(10'd512, 10'd512, 512);
    send_offset(10'd512, 10'd512, 511);
    send_offset(10'd512, 10'd512, -512);
    send_offset(10'd512, 10'd512, -511);
    // unit gains: saturate reverse, keep direction inside deadband, saturate forward
    load_settings(16'd256, 16'd256, 16'd256, 16'd512);
    send_item(clamp_setpoint(SP_MIN), '1, '0);
    send_offset(10'd300, 10'd700, 0);
    send_item(clamp_setpoint(SP_MAX), '0, '1);
    // tiny gain: negative drive truncating to zero runs forward
    load_settings(16'd1, 16'd0, 16'd0, 16'd0);
    send_offset(10'd100, 10'd900, -600);
    send_offset(10'd100, 10'd900, -70000);
    send_offset(10'd100, 10'd900, 0);
    // integral alone: wind into both clamps
    load_settings(16'd0, 16'hFFFF, 16'd0, 16'd512);
    repeat (3) send_offset(10'd640, 10'd380, 40000);
    repeat (2) send_offset(10'd640, 10'd380, -600000);
    // derivative alone across an error step
    load_settings(16'd0, 16'd0, 16'hFFFF, 16'd512);
    send_offset(10'd200, 10'd200, 1000);
    send_offset(10'd200, 10'd200, -1000);
  endtask

  task automatic random_part();
    int phase, n, run_len, k;
    int unsigned spread;
    longint bias, base;
    logic [SAMPLE_BITS-1:0] r0, l0;
    logic signed [SP_W-1:0] noise_sp;
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: load_settings('1, '1, '1, '0);
        1: load_settings('0, '0, '0, '1);
        2: load_settings(16'd256, 16'd16, 16'd4, 16'd512);
        default: load_settings(pick_gain(1024), pick_gain(256), pick_gain(64),
                               pick_deadband());
      endcase
      n = 0;
      while (n < PHASE_BEATS) begin
        // hold an operating point for a run, jittering the samples
        run_len = $urandom_range(1, 30);
        r0 = SAMPLE_BITS'($urandom_range(0, SMP_MAX));
        l0 = SAMPLE_BITS'($urandom_range(0, SMP_MAX));
        case ($urandom_range(0, 3))
          0: spread = 2 * int'(sb.deadband) + 64;
          1: spread = 4096;
          2: spread = 65536;
          default: spread = 400000;
        endcase
        bias = longint'($urandom_range(0, 2 * spread)) - longint'(spread);
        base = sb.sensed_angle(r0, l0) + bias;
        for (k = 0; k < run_len && n < PHASE_BEATS; k++) begin
          if ($urandom_range(0, 4) == 0) begin
            noise_sp = SP_W'($urandom);
            send_item(noise_sp, SAMPLE_BITS'($urandom_range(0, SMP_MAX)),
                      SAMPLE_BITS'($urandom_range(0, SMP_MAX)));
          end else begin
            send_item(clamp_setpoint(base), nudge(r0), nudge(l0));
          end
          n++;
        end
      end
    end
  endtask

  initial begin : stimulus
    in_ch.valid <= 1'b0;
    in_ch.setpoint <= '0;
    in_ch.right_sample <= '0;
    in_ch.left_sample <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_KP;
    cfg_data <= '0;
    rst_n <= 1'b0;
    burst_left = 1;
    settings_cnt = 1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    directed_part();
    random_part();
    drain();

    $display("covered %0d sensor beats over %0d register settings", sb.accepted,
             settings_cnt);
    $display("%0d inside deadband, %0d saturated, %0d reverse words, %0d integral clamps",
             sb.inside_cnt, sb.sat_cnt, sb.reverse_cnt, sb.clamp_cnt);
    if (sb.errors == 0) begin
      $display("flex_angle_pid_drive test passed");
    end else begin
      $display("flex_angle_pid_drive test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
